// ----- sv/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache table core.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int AGE_W     = 18;
    localparam int ELAPSED_W = 16;
    localparam int LIMIT_W   = 17;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;

    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = LIMIT_W'(20 * 60 * 60);
    localparam logic [AGE_W-1:0]   AGE_MAX         = {AGE_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_TICK   = 2'd3
    } arpc_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_ZERO_IP   = 2'd3
    } arpc_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT,
        ST_DONE
    } arpc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic finish;
    } arpc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } arpc_sts_t;

endpackage

// ----- sv/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer for one command: scan of every entry, commit, result hand-off.
// ----------------------------------------------------------------------------
module arpc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  arpc_pkg::arpc_sts_t sts,
    output arpc_pkg::arpc_cmd_t cmd
);
    import arpc_pkg::*;

    arpc_state_t state_reg;
    arpc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.commit = (state_reg == ST_COMMIT);
        cmd.finish = (state_reg == ST_DONE) && sts.out_free;
    end

endmodule

// ----- sv/arpc_datapath.sv -----
// ----------------------------------------------------------------------------
// arpc_datapath
// Entry tables, scan counter, per-entry evaluation and result register.
// ----------------------------------------------------------------------------
module arpc_datapath #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arpc_pkg::arpc_cmd_t           cmd,
    output arpc_pkg::arpc_sts_t           sts,
    input  logic                          cfg_wr_en,
    input  logic [arpc_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic [arpc_pkg::CMD_W-1:0]    in_command,
    input  logic [arpc_pkg::IP_W-1:0]     in_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]    in_mac_address,
    input  logic                          in_is_static,
    input  logic [arpc_pkg::ELAPSED_W-1:0] in_elapsed_time,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [arpc_pkg::STATUS_W-1:0] m_status,
    output logic [arpc_pkg::MAC_W-1:0]    m_found_mac,
    output logic                          m_send_request
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // entry tables
    logic [IP_W-1:0]  ip_mem  [ENTRIES];
    logic [MAC_W-1:0] mac_mem [ENTRIES];
    logic [AGE_W-1:0] age_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] static_reg;

    logic [LIMIT_W-1:0] age_limit_reg;

    // captured command
    arpc_op_t           op_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic               stat_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    // scan
    logic [IDX_W-1:0] cnt_reg;
    logic             eval_en_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;
    logic [AGE_W-1:0] rd_age_reg;

    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [MAC_W-1:0] match_mac_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             vic_found_reg;
    logic [IDX_W-1:0] vic_idx_reg;
    logic [AGE_W-1:0] vic_age_reg;

    // result register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [MAC_W-1:0]    m_found_mac_reg;
    logic                m_send_request_reg;

    logic             cur_valid;
    logic             cur_static;
    logic             hit;
    logic             tick_live;
    logic             tick_expire;
    logic [AGE_W:0]   age_sum;
    logic [AGE_W-1:0] age_sat;
    logic             ins_ok;
    logic [IDX_W-1:0] ins_idx;
    logic             age_we;
    logic [IDX_W-1:0] age_waddr;
    logic [AGE_W-1:0] age_wdata;
    arpc_status_t     res_status;

    always_comb begin
        cur_valid   = valid_reg[eval_idx_reg];
        cur_static  = static_reg[eval_idx_reg];
        hit         = cur_valid && (rd_ip_reg == ip_reg);
        tick_live   = eval_en_reg && (op_reg == CMD_TICK) && cur_valid && !cur_static;
        tick_expire = rd_age_reg > {1'b0, age_limit_reg};
        age_sum     = {1'b0, rd_age_reg} + {{(AGE_W + 1 - ELAPSED_W){1'b0}}, elapsed_reg};
        age_sat     = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];

        ins_ok  = (ip_reg != '0) && (match_found_reg || free_found_reg || vic_found_reg);
        ins_idx = match_found_reg ? match_idx_reg :
                  (free_found_reg ? free_idx_reg : vic_idx_reg);

        age_we    = 1'b0;
        age_waddr = eval_idx_reg;
        age_wdata = age_sat;
        if (tick_live && !tick_expire) begin
            age_we = 1'b1;
        end else if (cmd.commit && (op_reg == CMD_INSERT) && ins_ok) begin
            age_we    = 1'b1;
            age_waddr = ins_idx;
            age_wdata = '0;
        end
    end

    always_comb begin
        res_status = STS_OK;
        unique case (op_reg)
            CMD_INSERT: begin
                if (ip_reg == '0) begin
                    res_status = STS_ZERO_IP;
                end else if (!ins_ok) begin
                    res_status = STS_FULL;
                end
            end
            CMD_LOOKUP, CMD_REMOVE: begin
                if (!match_found_reg) begin
                    res_status = STS_NOT_FOUND;
                end
            end
            CMD_TICK: begin
                res_status = STS_OK;
            end
            default: begin
                res_status = STS_OK;
            end
        endcase
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (cmd.commit && (op_reg == CMD_INSERT) && ins_ok) begin
            ip_mem[ins_idx]  <= ip_reg;
            mac_mem[ins_idx] <= mac_reg;
        end
        if (age_we) begin
            age_mem[age_waddr] <= age_wdata;
        end
        if (cmd.scan) begin
            rd_ip_reg  <= ip_mem[cnt_reg];
            rd_mac_reg <= mac_mem[cnt_reg];
            rd_age_reg <= age_mem[cnt_reg];
        end
    end

    // valid and static bits, configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            static_reg    <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                age_limit_reg <= cfg_wr_data;
            end
            if (tick_live && tick_expire) begin
                valid_reg[eval_idx_reg] <= 1'b0;
            end
            if (cmd.commit) begin
                if ((op_reg == CMD_INSERT) && ins_ok) begin
                    valid_reg[ins_idx]  <= 1'b1;
                    static_reg[ins_idx] <= stat_reg;
                end else if ((op_reg == CMD_REMOVE) && match_found_reg) begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // command capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= arpc_op_t'(in_command);
            ip_reg      <= in_ip_address;
            mac_reg     <= in_mac_address;
            stat_reg    <= in_is_static;
            elapsed_reg <= in_elapsed_time;
        end
    end

    // scan counter and search state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            eval_en_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
        end else begin
            eval_en_reg <= cmd.scan;
            if (cmd.load) begin
                cnt_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                vic_found_reg   <= 1'b0;
            end else begin
                if (cmd.scan) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (eval_en_reg) begin
                    if (hit && !match_found_reg) begin
                        match_found_reg <= 1'b1;
                    end
                    if (!cur_valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                    end
                    if (cur_valid && !cur_static) begin
                        vic_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            eval_idx_reg <= cnt_reg;
        end
        if (eval_en_reg) begin
            if (hit && !match_found_reg) begin
                match_idx_reg <= eval_idx_reg;
                match_mac_reg <= rd_mac_reg;
            end
            if (!cur_valid && !free_found_reg) begin
                free_idx_reg <= eval_idx_reg;
            end
            if (cur_valid && !cur_static && (!vic_found_reg || (rd_age_reg > vic_age_reg))) begin
                vic_idx_reg <= eval_idx_reg;
                vic_age_reg <= rd_age_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_status_reg       <= res_status;
            m_found_mac_reg    <= ((op_reg == CMD_LOOKUP) && match_found_reg) ? match_mac_reg : '0;
            m_send_request_reg <= (op_reg == CMD_LOOKUP) && !match_found_reg;
        end
    end

    always_comb begin
        sts.scan_last  = cmd.scan && (cnt_reg == LAST_IDX);
        sts.out_free   = !m_tvalid_reg || m_tready;
        m_tvalid       = m_tvalid_reg;
        m_status       = m_status_reg;
        m_found_mac    = m_found_mac_reg;
        m_send_request = m_send_request_reg;
    end

endmodule

// ----- sv/arp_cache_table_core.sv -----
// ----------------------------------------------------------------------------
// arp_cache_table_core
// IPv4 to MAC cache with insert, lookup, remove and ageing tick commands.
// ----------------------------------------------------------------------------
// each command runs a table scan of one entry per cycle through a single memory read port,
//   then commit and result hand-off; the next command is taken only in idle, after the
//   previous command has passed its result to the output register
// a new command is taken while the previous result still waits on the output
// reset clears all valid and static bits and loads age_limit with 72000;
//   the address, mac and age tables are not cleared
// ----------------------------------------------------------------------------
module arp_cache_table_core #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [arpc_pkg::LIMIT_W-1:0]    cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ip_address[31:0], mac_address[79:32], is_static[80], elapsed_time[96:81]
    input  logic [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [arpc_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], found_mac[49:2], send_request[50]
    output logic [arpc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import arpc_pkg::*;

    arpc_cmd_t           ctl_cmd;
    arpc_sts_t           ctl_sts;
    logic [STATUS_W-1:0] res_status;
    logic [MAC_W-1:0]    res_found_mac;
    logic                res_send_request;

    arpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctl_cmd),
        .sts             (ctl_sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_command      (s_tuser),
        .in_ip_address   (s_tdata[31:0]),
        .in_mac_address  (s_tdata[79:32]),
        .in_is_static    (s_tdata[80]),
        .in_elapsed_time (s_tdata[96:81]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_status        (res_status),
        .m_found_mac     (res_found_mac),
        .m_send_request  (res_send_request)
    );

    assign m_tdata = {{(M_TDATA_W - 51){1'b0}}, res_send_request, res_found_mac, res_status};

endmodule
